// File: hdl/ttp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttp_pkg
// shared types and codes for the text tag parser
// ----------------------------------------------------------------------------
package ttp_pkg;

   // result kinds
   localparam logic [1:0] KIND_HEADER = 2'd0;
   localparam logic [1:0] KIND_VALUE  = 2'd1;
   localparam logic [1:0] KIND_END    = 2'd2;
   localparam logic [1:0] KIND_ERROR  = 2'd3;

   // error codes
   localparam logic [1:0] ERR_NONE      = 2'd0;
   localparam logic [1:0] ERR_SHORT_HDR = 2'd1;
   localparam logic [1:0] ERR_BAD_LEN   = 2'd2;
   localparam logic [1:0] ERR_TRUNC     = 2'd3;

   localparam int RSP_DATA_W = 64;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] tag_number;
      logic        constructed;
      logic [15:0] value_length;
      logic        no_length_field;
      logic [15:0] tag_offset;
      logic [7:0]  value_byte;
      logic        last_of_value;
      logic [1:0]  error_code;
   } rsp_type;

endpackage

// File: hdl/ttp_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttp_parser
// parser state and one-byte step logic, gives at most one result per item
// ----------------------------------------------------------------------------
module ttp_parser (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic             in_mode,
   input  logic [7:0]       in_byte,
   input  logic             mask_ctor,
   output logic             out_valid,
   output ttp_pkg::rsp_type out_rsp
);

   localparam logic [2:0] PH_TAG   = 3'd0;
   localparam logic [2:0] PH_AFTER = 3'd1;
   localparam logic [2:0] PH_LEN   = 3'd2;
   localparam logic [2:0] PH_VALUE = 3'd3;
   localparam logic [2:0] PH_HALT  = 3'd4;

   localparam logic [16:0] LEN_SAT = 17'h10000;

   logic [2:0]  phase_ff, phase_in;
   logic [1:0]  hcount_ff, hcount_in;
   logic [15:0] tag_ff, tag_in;
   logic [16:0] len_ff, len_in;
   logic        minus_ff, minus_in;
   logic        digit_ff, digit_in;
   logic [15:0] left_ff, left_in;
   logic [15:0] pos_ff, pos_in;
   logic [15:0] start_ff, start_in;

   logic        is_digit;
   logic [3:0]  dec;
   logic [15:0] hex_d;
   logic [19:0] len_mac;
   logic        len_bad;
   logic [15:0] hdr_tag;
   logic [15:0] tag_start;

   assign is_digit = (in_byte >= 8'h30) && (in_byte <= 8'h39);
   assign dec      = in_byte[3:0] - 4'h0;
   // unchecked digit formula, wraps modulo 2^16
   assign hex_d    = (in_byte > 8'h39) ? ({8'h00, in_byte} - 16'h0037)
                                       : ({8'h00, in_byte} - 16'h0030);
   assign len_mac  = {len_ff, 3'b000} + {2'b00, len_ff, 1'b0} + {16'h0000, dec};
   assign len_bad  = len_ff[16] || (minus_ff && (len_ff != 17'd0));
   assign hdr_tag  = {tag_ff[15] & ~mask_ctor, tag_ff[14:0]};
   // tag start as seen by this step (updated on first tag char)
   assign tag_start = start_ff;

   always_comb begin
      phase_in  = phase_ff;
      hcount_in = hcount_ff;
      tag_in    = tag_ff;
      len_in    = len_ff;
      minus_in  = minus_ff;
      digit_in  = digit_ff;
      left_in   = left_ff;
      pos_in    = pos_ff;
      start_in  = start_ff;
      out_valid = 1'b0;
      out_rsp   = '0;

      if (in_valid) begin
         if (in_mode) begin
            // end of message
            unique case (phase_ff)
               PH_TAG: begin
                  out_valid = 1'b1;
                  if (hcount_ff == 2'd0) begin
                     out_rsp.kind = ttp_pkg::KIND_END;
                  end else begin
                     out_rsp.kind       = ttp_pkg::KIND_ERROR;
                     out_rsp.tag_offset = tag_start;
                     out_rsp.error_code = ttp_pkg::ERR_SHORT_HDR;
                  end
               end
               PH_AFTER: begin
                  out_valid          = 1'b1;
                  out_rsp.kind       = ttp_pkg::KIND_ERROR;
                  out_rsp.tag_offset = tag_start;
                  out_rsp.error_code = ttp_pkg::ERR_SHORT_HDR;
               end
               PH_LEN: begin
                  out_valid          = 1'b1;
                  out_rsp.kind       = ttp_pkg::KIND_ERROR;
                  out_rsp.tag_offset = tag_start;
                  out_rsp.error_code = (!digit_ff || len_bad) ? ttp_pkg::ERR_BAD_LEN
                                                              : ttp_pkg::ERR_TRUNC;
               end
               PH_VALUE: begin
                  out_valid          = 1'b1;
                  out_rsp.kind       = ttp_pkg::KIND_ERROR;
                  out_rsp.tag_offset = tag_start;
                  out_rsp.error_code = ttp_pkg::ERR_TRUNC;
               end
               default: begin
               end
            endcase
            phase_in  = PH_TAG;
            hcount_in = 2'd0;
            tag_in    = '0;
            len_in    = '0;
            minus_in  = 1'b0;
            digit_in  = 1'b0;
            left_in   = '0;
            pos_in    = '0;
         end else begin
            pos_in = pos_ff + 16'd1;
            unique case (phase_ff)
               PH_TAG: begin
                  if ((hcount_ff == 2'd0) && (in_byte == 8'h0a)) begin
                     out_valid    = 1'b1;
                     out_rsp.kind = ttp_pkg::KIND_END;
                     phase_in     = PH_HALT;
                  end else begin
                     if (hcount_ff == 2'd0) begin
                        start_in = pos_ff;
                        tag_in   = hex_d;
                     end else begin
                        tag_in = {tag_ff[11:0], 4'h0} + hex_d;
                     end
                     hcount_in = hcount_ff + 2'd1;
                     if (hcount_ff == 2'd3) begin
                        phase_in = PH_AFTER;
                     end
                  end
               end
               PH_AFTER: begin
                  len_in   = '0;
                  minus_in = 1'b0;
                  digit_in = 1'b0;
                  if (in_byte == 8'h20) begin
                     out_valid               = 1'b1;
                     out_rsp.kind            = ttp_pkg::KIND_HEADER;
                     out_rsp.tag_number      = hdr_tag;
                     out_rsp.constructed     = tag_ff[15];
                     out_rsp.no_length_field = 1'b1;
                     out_rsp.tag_offset      = tag_start;
                     phase_in                = PH_TAG;
                  end else if (in_byte == 8'h2d) begin
                     minus_in = 1'b1;
                     phase_in = PH_LEN;
                  end else if (is_digit) begin
                     digit_in = 1'b1;
                     len_in   = {13'd0, dec};
                     phase_in = PH_LEN;
                  end else begin
                     out_valid          = 1'b1;
                     out_rsp.kind       = ttp_pkg::KIND_ERROR;
                     out_rsp.tag_offset = tag_start;
                     out_rsp.error_code = ttp_pkg::ERR_BAD_LEN;
                     phase_in           = PH_HALT;
                  end
               end
               PH_LEN: begin
                  if (is_digit) begin
                     digit_in = 1'b1;
                     // saturate at one past the largest legal length
                     len_in = (len_mac > {3'b000, LEN_SAT}) ? LEN_SAT : len_mac[16:0];
                  end else if (!digit_ff || len_bad) begin
                     out_valid          = 1'b1;
                     out_rsp.kind       = ttp_pkg::KIND_ERROR;
                     out_rsp.tag_offset = tag_start;
                     out_rsp.error_code = ttp_pkg::ERR_BAD_LEN;
                     phase_in           = PH_HALT;
                  end else begin
                     out_valid            = 1'b1;
                     out_rsp.kind         = ttp_pkg::KIND_HEADER;
                     out_rsp.tag_number   = hdr_tag;
                     out_rsp.constructed  = tag_ff[15];
                     out_rsp.value_length = len_ff[15:0];
                     out_rsp.tag_offset   = tag_start;
                     left_in              = len_ff[15:0];
                     phase_in             = (len_ff[15:0] == 16'd0) ? PH_TAG : PH_VALUE;
                  end
               end
               PH_VALUE: begin
                  out_valid             = 1'b1;
                  out_rsp.kind          = ttp_pkg::KIND_VALUE;
                  out_rsp.value_byte    = in_byte;
                  out_rsp.last_of_value = (left_ff <= 16'd1);
                  left_in               = (left_ff == 16'd0) ? 16'd0 : left_ff - 16'd1;
                  if (left_ff <= 16'd1) begin
                     phase_in = PH_TAG;
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_TAG;
         hcount_ff <= '0;
         tag_ff    <= '0;
         len_ff    <= '0;
         minus_ff  <= 1'b0;
         digit_ff  <= 1'b0;
         left_ff   <= '0;
         pos_ff    <= '0;
         start_ff  <= '0;
      end else begin
         phase_ff  <= phase_in;
         hcount_ff <= hcount_in;
         tag_ff    <= tag_in;
         len_ff    <= len_in;
         minus_ff  <= minus_in;
         digit_ff  <= digit_in;
         left_ff   <= left_in;
         pos_ff    <= pos_in;
         start_ff  <= start_in;
      end
   end

endmodule

// File: hdl/ttp_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttp_out_buf
// two-entry result register, decouples result ready from input ready
// ----------------------------------------------------------------------------
module ttp_out_buf (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_valid,
   input  ttp_pkg::rsp_type wr_data,
   output logic             has_space,
   output logic             rd_valid,
   input  logic             rd_ready,
   output ttp_pkg::rsp_type rd_data
);

   ttp_pkg::rsp_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_wr, do_rd;

   assign has_space = (count_ff != 2'd2);
   assign rd_valid  = (count_ff != 2'd0);
   assign rd_data   = entry_ff[rd_ptr_ff];
   assign do_wr     = wr_valid && has_space;
   assign do_rd     = rd_valid && rd_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_wr;
      rd_ptr_in = rd_ptr_ff ^ do_rd;
      count_in  = count_ff + {1'b0, do_wr} - {1'b0, do_rd};
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: hdl/text_tlv_tag_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_tlv_tag_parser
// streaming parser for text tag messages: hex tag, optional decimal length,
// value bytes; emits header, value byte, end and error items
// ----------------------------------------------------------------------------
// result path: a result item is written to the result buffer when the req
//   item that caused it is accepted, and reaches rsp after older results
// throughput: one req item per cycle while the buffer has a free entry; the
//   parser step is combinational and the two-entry result buffer keeps
//   req_tready up while one result waits
// reset: synchronous, active high; parser waits for a tag start, position 0,
//   constructed masking off, result buffer empty
module text_tlv_tag_parser (
   input  logic        clock,
   input  logic        reset,
   // config: constructed-bit masking
   input  logic        csr_we,
   input  logic        csr_wdata,        // mask_constructor
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,        // [7:0] data_byte
   input  logic        req_tuser,        // [0] mode (1 = end of message)
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [15:0] tag_number, [16] constructed, [32:17] value_length,
   // [33] no_length_field, [49:34] tag_offset, [57:50] value_byte,
   // [59:58] error_code, [63:60] zero
   output logic [ttp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic        rsp_tlast,        // last_of_value
   output logic [1:0]  rsp_tuser         // [1:0] kind
);

   logic             mask_ff;
   logic             req_accept;
   logic             res_valid;
   ttp_pkg::rsp_type res;
   ttp_pkg::rsp_type head;
   logic             buf_space;

   // config register; must be written only while idle, unchecked here
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= 1'b0;
      end else if (csr_we) begin
         mask_ff <= csr_wdata;
      end
   end

   // one item accepted whenever the buffer has a free entry
   assign req_tready = buf_space;
   assign req_accept = req_tvalid && req_tready;

   ttp_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_accept),
      .in_mode   (req_tuser),
      .in_byte   (req_tdata),
      .mask_ctor (mask_ff),
      .out_valid (res_valid),
      .out_rsp   (res)
   );

   ttp_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .wr_valid  (res_valid),
      .wr_data   (res),
      .has_space (buf_space),
      .rd_valid  (rsp_tvalid),
      .rd_ready  (rsp_tready),
      .rd_data   (head)
   );

   // pack result fields, tag_number in the lowest bits
   assign rsp_tdata = {4'b0000,
                       head.error_code,
                       head.value_byte,
                       head.tag_offset,
                       head.no_length_field,
                       head.value_length,
                       head.constructed,
                       head.tag_number};
   assign rsp_tlast = head.last_of_value;
   assign rsp_tuser = head.kind;

endmodule

// File: sim/tb_text_tlv_tag_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_tlv_tag_parser
// self-checking bench for the text tag parser: builds tag messages (well formed,
// broken and noise), predicts every header, value, end and error item in a
// scoreboard and compares each rsp item field by field under random back pressure
// ----------------------------------------------------------------------------
module tb_text_tlv_tag_parser;

   // character codes the parser reacts to
   localparam logic [7:0] CH_NL    = 8'h0a;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_SEVEN = 8'h37;
   localparam logic [7:0] CH_NINE  = 8'h39;

   localparam int unsigned LEN_MAX     = 65535;  // largest legal value length
   localparam int unsigned END_MARK    = 256;    // end-of-message marker in a built message
   localparam int unsigned PER_PHASE   = 360;    // counted items per random phase, at least
   localparam int unsigned STALL_LIMIT = 2000;   // cycles without any handshake

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic        csr_wdata = 1'b0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] data_byte
   logic        req_tuser = 1'b0;    // [0] mode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // [15:0] tag_number, [16] constructed, [32:17] value_length,
   // [33] no_length_field, [49:34] tag_offset, [57:50] value_byte,
   // [59:58] error_code, [63:60] zero
   logic [ttp_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic        rsp_tlast;           // last_of_value
   logic [1:0]  rsp_tuser;           // [1:0] kind

   int unsigned send_idle_pct = 14;
   int unsigned recv_idle_pct = 79;

   function automatic bit is_digit(logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   // scoreboard: mirrors the parser state and holds the items still owed on rsp
   class tlv_result_board;
      typedef enum logic [2:0] {WAIT_TAG, AFTER_TAG, IN_LENGTH, IN_VALUE, HALTED}
         parse_state_type;

      parse_state_type  state = WAIT_TAG;
      bit               mask_ctor = 1'b0;
      int unsigned      hdr_cnt = 0;
      logic [15:0]      tag_acc = '0;
      int unsigned      len_acc = 0;    // saturates one above LEN_MAX
      bit               minus = 1'b0;
      bit               digits = 1'b0;
      int unsigned      remaining = 0;
      logic [15:0]      pos = '0;       // wraps with the message byte count
      logic [15:0]      tag_pos = '0;
      ttp_pkg::rsp_type pending_results[$];
      int unsigned      mismatches = 0;

      function void set_mask(bit v);
         mask_ctor = v;
      endfunction

      function int unsigned pending();
         return pending_results.size();
      endfunction

      function void add_result(ttp_pkg::rsp_type e);
         pending_results.insert(pending_results.size(), e);
      endfunction

      function bit length_bad();
         return len_acc > LEN_MAX || (minus && len_acc != 0);
      endfunction

      function void push_end();
         ttp_pkg::rsp_type e;
         e = '0;
         e.kind = ttp_pkg::KIND_END;
         add_result(e);
      endfunction

      function void push_error(logic [1:0] code);
         ttp_pkg::rsp_type e;
         e = '0;
         e.kind = ttp_pkg::KIND_ERROR;
         e.tag_offset = tag_pos;
         e.error_code = code;
         add_result(e);
         state = HALTED;
      endfunction

      function void push_header(logic [15:0] len, bit nolen);
         ttp_pkg::rsp_type e;
         e = '0;
         e.kind = ttp_pkg::KIND_HEADER;
         e.tag_number = mask_ctor ? {1'b0, tag_acc[14:0]} : tag_acc;
         e.constructed = tag_acc[15];
         e.value_length = len;
         e.no_length_field = nolen;
         e.tag_offset = tag_pos;
         add_result(e);
      endfunction

      function void note_input(logic eom, logic [7:0] c);
         logic [15:0]      here;
         logic [15:0]      d;
         ttp_pkg::rsp_type e;
         if (eom) begin
            case (state)
               WAIT_TAG: begin
                  if (hdr_cnt == 0) push_end();
                  else push_error(ttp_pkg::ERR_SHORT_HDR);
               end
               AFTER_TAG: push_error(ttp_pkg::ERR_SHORT_HDR);
               IN_LENGTH: push_error((!digits || length_bad()) ? ttp_pkg::ERR_BAD_LEN
                                                               : ttp_pkg::ERR_TRUNC);
               IN_VALUE:  push_error(ttp_pkg::ERR_TRUNC);
               default: ;
            endcase
            // every end mark rewinds the parser, tag_pos is kept
            state = WAIT_TAG;
            hdr_cnt = 0;
            tag_acc = '0;
            len_acc = 0;
            minus = 1'b0;
            digits = 1'b0;
            remaining = 0;
            pos = '0;
         end else begin
            here = pos;
            pos = pos + 16'd1;
            case (state)
               WAIT_TAG: begin
                  if (hdr_cnt == 0 && c == CH_NL) begin
                     push_end();
                     state = HALTED;
                  end else begin
                     if (hdr_cnt == 0) begin
                        tag_pos = here;
                        tag_acc = '0;
                     end
                     // unchecked digit value, wraps at 16 bits
                     d = (c > CH_NINE) ? {8'h00, c} - {8'h00, CH_SEVEN}
                                       : {8'h00, c} - {8'h00, CH_ZERO};
                     tag_acc = {tag_acc[11:0], 4'h0} + d;
                     hdr_cnt++;
                     if (hdr_cnt == 4) begin
                        hdr_cnt = 0;
                        state = AFTER_TAG;
                     end
                  end
               end
               AFTER_TAG: begin
                  len_acc = 0;
                  minus = 1'b0;
                  digits = 1'b0;
                  if (c == CH_SPACE) begin
                     push_header(16'h0000, 1'b1);
                     state = WAIT_TAG;
                  end else if (c == CH_MINUS) begin
                     minus = 1'b1;
                     state = IN_LENGTH;
                  end else if (is_digit(c)) begin
                     digits = 1'b1;
                     len_acc = c - CH_ZERO;
                     state = IN_LENGTH;
                  end else begin
                     push_error(ttp_pkg::ERR_BAD_LEN);
                  end
               end
               IN_LENGTH: begin
                  if (is_digit(c)) begin
                     digits = 1'b1;
                     len_acc = len_acc * 10 + (c - CH_ZERO);
                     if (len_acc > LEN_MAX + 1) len_acc = LEN_MAX + 1;
                  end else if (!digits || length_bad()) begin
                     push_error(ttp_pkg::ERR_BAD_LEN);
                  end else begin
                     push_header(len_acc[15:0], 1'b0);
                     remaining = len_acc;
                     state = (len_acc == 0) ? WAIT_TAG : IN_VALUE;
                  end
               end
               IN_VALUE: begin
                  e = '0;
                  e.kind = ttp_pkg::KIND_VALUE;
                  e.value_byte = c;
                  if (remaining > 0) remaining--;
                  e.last_of_value = (remaining == 0);
                  if (remaining == 0) state = WAIT_TAG;
                  add_result(e);
               end
               default: ;
            endcase
         end
      endfunction

      task report(string what);
         mismatches++;
         $display("mismatch: %s (at %0t)", what, $time);
      endtask

      task compare_field(string name, logic [15:0] got, logic [15:0] want);
         if (got !== want) report($sformatf("%s got %0h expected %0h", name, got, want));
      endtask

      task check_result(logic [ttp_pkg::RSP_DATA_W-1:0] data, logic last, logic [1:0] user);
         ttp_pkg::rsp_type want;
         if (pending_results.size() == 0) begin
            report($sformatf("unexpected rsp item, kind %0d", user));
         end else begin
            want = pending_results.pop_front();
            compare_field("kind", user, want.kind);
            compare_field("tag_number", data[15:0], want.tag_number);
            compare_field("constructed", data[16], want.constructed);
            compare_field("value_length", data[32:17], want.value_length);
            compare_field("no_length_field", data[33], want.no_length_field);
            compare_field("tag_offset", data[49:34], want.tag_offset);
            compare_field("value_byte", data[57:50], want.value_byte);
            compare_field("error_code", data[59:58], want.error_code);
            compare_field("last_of_value", last, want.last_of_value);
            compare_field("padding", data[63:60], 16'h0000);
         end
      endtask
   endclass

   tlv_result_board board;

   text_tlv_tag_parser i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // receiver back pressure, changes on the falling edge
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // monitor: results are checked before the same edge's input is noted,
   // since an input never answers in its own cycle
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) board.check_result(rsp_tdata, rsp_tlast, rsp_tuser);
         if (req_tvalid && req_tready) board.note_input(req_tuser, req_tdata);
      end
   end

   // watchdog on handshake progress
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("TB_ERROR");
      $finish;
   end

   // ------------------------------------------------------------------------
   // message building: entries are bytes, or END_MARK for the end-of-message item
   // ------------------------------------------------------------------------
   int unsigned msg_q[$];
   int unsigned counted = 0;   // built items that drive the parser, noise excluded

   function automatic void put(int unsigned v);
      msg_q.insert(msg_q.size(), v);
      counted++;
   endfunction

   // bytes the parser ignores once halted
   function automatic void put_noise(int unsigned n);
      repeat (n) msg_q.insert(msg_q.size(), $urandom_range(255));
   endfunction

   function automatic void put_text(string s);
      foreach (s[i]) put(s[i]);
   endfunction

   // mostly upper-case hex, some lower case and some arbitrary bytes
   function automatic logic [7:0] tag_char();
      string       upper;
      string       lower;
      int unsigned r;
      upper = "0123456789ABCDEF";
      lower = "abcdef";
      r = $urandom_range(99);
      if (r < 80) return upper[$urandom_range(15)];
      else if (r < 90) return lower[$urandom_range(5)];
      else return 8'($urandom_range(255));
   endfunction

   function automatic void put_tag(int unsigned n);
      repeat (n) put(tag_char());
   endfunction

   // any byte that does not extend a length
   function automatic logic [7:0] sep_char();
      logic [7:0] b;
      do b = 8'($urandom_range(255)); while (is_digit(b));
      return b;
   endfunction

   function automatic logic [7:0] bad_length_char();
      logic [7:0] b;
      do b = 8'($urandom_range(255)); while (is_digit(b) || b == CH_SPACE || b == CH_MINUS);
      return b;
   endfunction

   function automatic int unsigned pick_len();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 70) return $urandom_range(0, 4);
      else if (r < 95) return $urandom_range(5, 30);
      else return $urandom_range(31, 300);
   endfunction

   // decimal length, now and then with a leading zero
   function automatic void put_len(int unsigned len);
      if ($urandom_range(7) == 0) put(CH_ZERO);
      put_text($sformatf("%0d", len));
   endfunction

   // one broken tag; the message ends right after it
   function automatic void put_broken();
      int unsigned len;
      case ($urandom_range(6))
         0: put_tag($urandom_range(1, 4));              // end inside or right after the tag
         1: begin
            put_tag(4);
            put(bad_length_char());
            put_noise($urandom_range(0, 3));
         end
         2: begin                                       // minus with no digits
            put_tag(4);
            put(CH_MINUS);
            if ($urandom_range(1)) put(sep_char());
         end
         3: begin                                       // negative length
            put_tag(4);
            put(CH_MINUS);
            put_len($urandom_range(1, 99));
            if ($urandom_range(1)) put(sep_char());
         end
         4: begin                                       // oversized, saturating length
            put_tag(4);
            if ($urandom_range(3) == 0) put_len(LEN_MAX + 1);
            else put_len($urandom_range(LEN_MAX + 1, 99999999));
            if ($urandom_range(1)) put(sep_char());
            put_noise($urandom_range(0, 3));
         end
         5: begin                                       // digits, then the end
            put_tag(4);
            put_len(pick_len());
         end
         default: begin                                 // value cut short
            put_tag(4);
            len = $urandom_range(1, 20);
            put_len(len);
            put(sep_char());
            repeat ($urandom_range(0, len - 1)) put($urandom_range(255));
         end
      endcase
   endfunction

   function automatic void build_random_message();
      int unsigned ntags;
      int unsigned len;
      int unsigned r;
      bit          broken;
      msg_q.delete();
      broken = 1'b0;
      if ($urandom_range(99) < 4) begin
         // raw noise, parsed as whatever it happens to be
         repeat ($urandom_range(0, 12)) put($urandom_range(255));
      end else begin
         ntags = $urandom_range(0, 4);
         for (int t = 0; t < ntags && !broken; t++) begin
            r = $urandom_range(99);
            if (r < 25) begin
               put_tag(4);
               put(CH_SPACE);
            end else if (r < 85) begin
               put_tag(4);
               len = pick_len();
               put_len(len);
               put(sep_char());
               repeat (len) put($urandom_range(255));
            end else if (r < 90) begin
               // minus zero is a legal empty length
               put_tag(4);
               put(CH_MINUS);
               repeat ($urandom_range(1, 2)) put(CH_ZERO);
               put(sep_char());
            end else begin
               broken = 1'b1;
               put_broken();
            end
         end
         if (!broken && $urandom_range(9) == 0) begin
            put(CH_NL);
            put_noise($urandom_range(0, 4));
         end
      end
      put(END_MARK);
   endfunction

   // ------------------------------------------------------------------------
   // drivers, all entered just after a falling edge
   // ------------------------------------------------------------------------
   task automatic send_item(bit eom, logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser = eom;
      req_tdata = b;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic send_message();
      foreach (msg_q[i]) begin
         if (msg_q[i] == END_MARK) send_item(1'b1, 8'($urandom_range(255)));
         else send_item(1'b0, msg_q[i][7:0]);
      end
   endtask

   // hold the sender until every owed item is out and the pipe has settled
   task automatic drain();
      req_tvalid = 1'b0;
      while (board.pending() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_mask(bit v);
      drain();
      csr_we = 1'b1;
      csr_wdata = v;
      @(negedge clock);
      csr_we = 1'b0;
      board.set_mask(v);
   endtask

   task automatic run_random_phase();
      int unsigned stop_at;
      stop_at = counted + PER_PHASE;
      while (counted < stop_at) begin
         if ($urandom_range(24) == 0) drain();
         build_random_message();
         send_message();
      end
   endtask

   initial begin
      board = new();
      repeat (11) @(negedge clock);
      reset = 1'b0;

      // sender idles rarely, receiver stalls most cycles
      send_idle_pct = 14;
      recv_idle_pct = 79;
      write_mask(1'b1);

      // directed: newline end with a later end mark ignored, end at tag start,
      // odd hex digit with minus zero length, value bytes 00 and ff,
      // end inside a tag
      msg_q.delete();
      put(CH_NL);
      put(END_MARK);
      put(END_MARK);
      put_text("FfFF");
      put(CH_MINUS);
      put(CH_ZERO);
      put(8'hff);
      put_text("0000");
      put_text("2");
      put(8'h00);
      put(8'h00);
      put(8'hff);
      put_text("zz");
      put(END_MARK);
      send_message();

      run_random_phase();

      // swap: sender idles most, receiver rarely
      write_mask(1'b0);
      send_idle_pct = 79;
      recv_idle_pct = 14;
      run_random_phase();

      // no idling on either side
      write_mask(1'b1);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random_phase();

      // largest legal length in a header, value cut short by the end mark
      msg_q.delete();
      put_text("ABCD");
      put(CH_SPACE);
      put_text("8001");
      put_len(LEN_MAX);
      put(sep_char());
      repeat (5) put($urandom_range(255));
      put(END_MARK);
      send_message();

      // wait for the last owed items, then watch for strays
      drain();
      repeat (10) @(negedge clock);
      if (board.mismatches == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule
